// ===== rtl/hcbd_pkg.sv =====
// shared types, constants, byte classification and size-line parsing helpers for the chunked body decoder
package hcbd_pkg;

	localparam int SIZE_BITS = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PHASE_W = 4;

	localparam logic [PHASE_W-1:0] PH_LWS = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SIGN = 4'd1;
	localparam logic [PHASE_W-1:0] PH_DIGITS = 4'd2;
	localparam logic [PHASE_W-1:0] PH_REST = 4'd3;
	localparam logic [PHASE_W-1:0] PH_DATA = 4'd4;
	localparam logic [PHASE_W-1:0] PH_DCR = 4'd5;
	localparam logic [PHASE_W-1:0] PH_DLF = 4'd6;
	localparam logic [PHASE_W-1:0] PH_TRAIL = 4'd7;
	localparam logic [PHASE_W-1:0] PH_DONE = 4'd8;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
	localparam logic [2:0] ERR_NEGATIVE = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_NO_CRLF = 3'd4;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic [7:0] data;
		logic start;
		logic is_cr;
		logic is_lf;
		logic is_space;
		logic is_plus;
		logic is_minus;
		logic is_x;
		logic is_hex;
		logic [3:0] hex_val;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [SIZE_BITS-1:0] acc;
		logic neg;
		logic dig;
		logic pre;
		logic ovr;
	} line_t;

	function automatic item_t classify(input logic [7:0] c, input logic start);
		item_t r;
		r = '0;
		r.data = c;
		r.start = start;
		r.is_cr = (c == CH_CR);
		r.is_lf = (c == CH_LF);
		r.is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		r.is_plus = (c == 8'h2B);
		r.is_minus = (c == 8'h2D);
		r.is_x = (c == 8'h78) || (c == 8'h58);
		if (c >= 8'h30 && c <= 8'h39) begin
			r.is_hex = 1'b1;
			r.hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.is_hex = 1'b1;
			r.hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.is_hex = 1'b1;
			r.hex_val = 4'(c - 8'h37);
		end
		return r;
	endfunction

	function automatic line_t take_digit(input line_t l, input item_t it);
		line_t r;
		r = l;
		if (!it.is_hex) begin
			r.phase = PH_REST;
		end else begin
			r.pre = !l.dig && (it.hex_val == 4'd0);
			r.dig = 1'b1;
			if (l.acc[SIZE_BITS-1:SIZE_BITS-4] != 4'd0) begin
				r.ovr = 1'b1;
			end else if (!l.ovr) begin
				r.acc = {l.acc[SIZE_BITS-5:0], it.hex_val};
			end
			r.phase = PH_DIGITS;
		end
		return r;
	endfunction

	function automatic line_t line_char(input line_t l, input item_t it);
		line_t r;
		r = l;
		case (l.phase)
			PH_LWS: begin
				if (it.is_space) begin
					r = l;
				end else if (it.is_plus) begin
					r.phase = PH_SIGN;
				end else if (it.is_minus) begin
					r.neg = 1'b1;
					r.phase = PH_SIGN;
				end else begin
					r = take_digit(l, it);
				end
			end
			PH_SIGN: begin
				r = take_digit(l, it);
			end
			PH_DIGITS: begin
				if (l.pre && it.is_x) begin
					r.pre = 1'b0;
				end else begin
					r = take_digit(l, it);
				end
			end
			default: begin
				r = l;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/hcbd_front.sv =====
// front end: accepts input beats, classifies each byte and pushes it to the queue
module hcbd_front (
	input logic in_valid,
	input logic [7:0] in_byte,
	input logic start_body,
	input hcbd_pkg::q_status_t q_status,
	output logic in_stall,
	output logic push,
	output hcbd_pkg::item_t push_item
);

	assign in_stall = q_status.full;
	assign push = in_valid && !q_status.full;
	assign push_item = hcbd_pkg::classify(in_byte, start_body);

endmodule

// ===== rtl/hcbd_queue.sv =====
// short queue of classified bytes between front and back end
module hcbd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hcbd_pkg::item_t push_item,
	input logic pop,
	output hcbd_pkg::item_t pop_item,
	output hcbd_pkg::q_status_t q_status
);

	hcbd_pkg::item_t entry_q [hcbd_pkg::QUEUE_DEPTH];
	logic [hcbd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hcbd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hcbd_pkg::QCNT_W-1:0] count_q;

	assign q_status.full = (count_q == hcbd_pkg::QCNT_W'(hcbd_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hcbd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hcbd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + hcbd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - hcbd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/hcbd_back.sv =====
// back end: chunk parsing state machine and output register
module hcbd_back (
	input logic clk,
	input logic arst_n,
	input hcbd_pkg::item_t pop_item,
	input hcbd_pkg::q_status_t q_status,
	output logic pop,
	input logic res_stall,
	output logic res_valid,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic body_done,
	output logic [2:0] error_code,
	output logic byte_ignored
);

	localparam int SB = hcbd_pkg::SIZE_BITS;

	logic [hcbd_pkg::PHASE_W-1:0] phase_q;
	logic [SB-1:0] acc_q;
	logic [SB-1:0] left_q;
	logic neg_q, dig_q, pre_q, ovr_q, pcr_q;
	logic [1:0] tm_q;
	logic [2:0] err_q;

	logic res_valid_q;
	logic [7:0] out_byte_q;
	logic out_valid_q, body_done_q, byte_ignored_q;
	logic [2:0] error_code_q;

	hcbd_pkg::line_t cur_line, nxt_line, cr_line;
	hcbd_pkg::item_t cr_item;
	logic [SB-1:0] cur_left, nxt_left, dec_left;
	logic cur_pcr, nxt_pcr;
	logic [1:0] cur_tm, nxt_tm;
	logic [2:0] cur_err, nxt_err;
	logic ob_en, ign;

	assign pop = !q_status.empty && (!res_valid_q || !res_stall);
	assign cr_item = hcbd_pkg::classify(hcbd_pkg::CH_CR, 1'b0);
	assign dec_left = cur_left - SB'(1);

	always_comb begin
		if (pop_item.start) begin
			cur_line = '0;
			cur_line.phase = hcbd_pkg::PH_LWS;
			cur_left = '0;
			cur_pcr = 1'b0;
			cur_tm = 2'd0;
			cur_err = hcbd_pkg::ERR_NONE;
		end else begin
			cur_line.phase = phase_q;
			cur_line.acc = acc_q;
			cur_line.neg = neg_q;
			cur_line.dig = dig_q;
			cur_line.pre = pre_q;
			cur_line.ovr = ovr_q;
			cur_left = left_q;
			cur_pcr = pcr_q;
			cur_tm = tm_q;
			cur_err = err_q;
		end

		nxt_line = cur_line;
		nxt_left = cur_left;
		nxt_pcr = cur_pcr;
		nxt_tm = cur_tm;
		nxt_err = cur_err;
		ob_en = 1'b0;
		ign = 1'b0;
		cr_line = hcbd_pkg::line_char(cur_line, cr_item);

		if (cur_err != hcbd_pkg::ERR_NONE || cur_line.phase == hcbd_pkg::PH_DONE) begin
			ign = 1'b1;
		end else if (cur_line.phase <= hcbd_pkg::PH_REST) begin
			if (pop_item.is_cr) begin
				if (cur_pcr) begin
					nxt_line = cr_line;
				end
				nxt_pcr = 1'b1;
			end else if (pop_item.is_lf && cur_pcr) begin
				nxt_pcr = 1'b0;
				if (!cur_line.dig) begin
					nxt_err = hcbd_pkg::ERR_NO_DIGITS;
				end else if (cur_line.neg && (cur_line.acc != '0 || cur_line.ovr)) begin
					nxt_err = hcbd_pkg::ERR_NEGATIVE;
				end else if (cur_line.ovr) begin
					nxt_err = hcbd_pkg::ERR_OVERFLOW;
				end else if (cur_line.acc == '0) begin
					nxt_line.phase = hcbd_pkg::PH_TRAIL;
					nxt_tm = 2'd2;
				end else begin
					nxt_left = cur_line.acc;
					nxt_line.phase = hcbd_pkg::PH_DATA;
				end
			end else begin
				nxt_pcr = 1'b0;
				nxt_line = hcbd_pkg::line_char(cur_pcr ? cr_line : cur_line, pop_item);
			end
		end else begin
			case (cur_line.phase)
				hcbd_pkg::PH_DATA: begin
					ob_en = 1'b1;
					nxt_left = dec_left;
					if (dec_left == '0) begin
						nxt_line.phase = hcbd_pkg::PH_DCR;
					end
				end
				hcbd_pkg::PH_DCR: begin
					if (pop_item.is_cr) begin
						nxt_line.phase = hcbd_pkg::PH_DLF;
					end else begin
						nxt_err = hcbd_pkg::ERR_NO_CRLF;
					end
				end
				hcbd_pkg::PH_DLF: begin
					if (pop_item.is_lf) begin
						nxt_line = '0;
						nxt_line.phase = hcbd_pkg::PH_LWS;
						nxt_pcr = 1'b0;
					end else begin
						nxt_err = hcbd_pkg::ERR_NO_CRLF;
					end
				end
				default: begin
					if (pop_item.is_cr) begin
						nxt_tm = (cur_tm == 2'd2) ? 2'd3 : 2'd1;
					end else if (pop_item.is_lf) begin
						if (cur_tm == 2'd3) begin
							nxt_line.phase = hcbd_pkg::PH_DONE;
							nxt_tm = 2'd0;
						end else begin
							nxt_tm = (cur_tm == 2'd1) ? 2'd2 : 2'd0;
						end
					end else begin
						nxt_tm = 2'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_LWS;
			acc_q <= '0;
			left_q <= '0;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
			pre_q <= 1'b0;
			ovr_q <= 1'b0;
			pcr_q <= 1'b0;
			tm_q <= 2'd0;
			err_q <= hcbd_pkg::ERR_NONE;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= nxt_line.phase;
				acc_q <= nxt_line.acc;
				left_q <= nxt_left;
				neg_q <= nxt_line.neg;
				dig_q <= nxt_line.dig;
				pre_q <= nxt_line.pre;
				ovr_q <= nxt_line.ovr;
				pcr_q <= nxt_pcr;
				tm_q <= nxt_tm;
				err_q <= nxt_err;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= ob_en ? pop_item.data : 8'd0;
			out_valid_q <= ob_en;
			body_done_q <= (nxt_line.phase == hcbd_pkg::PH_DONE);
			error_code_q <= nxt_err;
			byte_ignored_q <= ign;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte = out_byte_q;
	assign out_valid = out_valid_q;
	assign body_done = body_done_q;
	assign error_code = error_code_q;
	assign byte_ignored = byte_ignored_q;

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// top level of the http chunked body decoder
// usage:
//   input channel: in_valid / in_stall, payload in_byte and start_body. one beat per
//   body byte; start_body clears all decoder state before that byte is handled.
//   result channel: res_valid / res_stall, payload out_byte, out_valid, body_done,
//   error_code and byte_ignored. exactly one result beat per input beat, in order.
// path: a beat accepted at a clock edge is classified and written into the queue at that
//   edge, then parsed when the back end pops it and held in the result register.
// throughput: one byte per cycle while bytes are queued and res_stall is low, set by the
//   parse step in the back end whose state every byte depends on.
// stalls: the back end holds a valid result in its register while res_stall is high and the
//   four-entry queue absorbs incoming beats; in_stall rises only when the queue is full.
// reset: arst_n clears the queue, the result valid flag and all parse state, which
//   equals starting a new body with the size line's leading white space.
// errors and the done flag are sticky until the next start_body; bytes seen after
//   either one come back with byte_ignored set.
module http_chunked_body_decoder (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	input logic start_body,
	output logic res_valid,
	input logic res_stall,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic body_done,
	output logic [2:0] error_code,
	output logic byte_ignored
);

	hcbd_pkg::q_status_t q_status;
	hcbd_pkg::item_t push_item;
	hcbd_pkg::item_t pop_item;
	logic push;
	logic pop;

	hcbd_front u_front (
		.in_valid(in_valid),
		.in_byte(in_byte),
		.start_body(start_body),
		.q_status(q_status),
		.in_stall(in_stall),
		.push(push),
		.push_item(push_item)
	);

	hcbd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.q_status(q_status)
	);

	hcbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_item(pop_item),
		.q_status(q_status),
		.pop(pop),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.body_done(body_done),
		.error_code(error_code),
		.byte_ignored(byte_ignored)
	);

endmodule

// ===== rtl/hcbd_checker.sv =====
// port-level checks for the chunked body decoder and their bind
module hcbd_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input logic [7:0] out_byte,
	input logic out_valid,
	input logic body_done,
	input logic [2:0] error_code,
	input logic byte_ignored
);

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |->
			error_code == hcbd_pkg::ERR_NONE && !body_done && !byte_ignored)
		else $error("data beat with error, done or ignore flag");

	a_ignore_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_ignored |-> error_code != hcbd_pkg::ERR_NONE || body_done)
		else $error("ignored beat without error or done");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("non-data beat carries a byte");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(error_code))
		else $error("stalled result beat changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// ===== tb/tb_http_chunked_body_decoder.sv =====
// testbench for the http chunked body decoder: directed and random byte streams checked beat by beat
module tb_http_chunked_body_decoder;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int RANDOM_BEATS = 850;

	typedef struct packed {
		logic [7:0] data;
		logic data_valid;
		logic done;
		logic [2:0] err;
		logic ignored;
	} decoded_t;

	class chunk_scoreboard;
		logic [hcbd_pkg::PHASE_W-1:0] phase;
		logic [hcbd_pkg::SIZE_BITS-1:0] size_acc;
		logic [hcbd_pkg::SIZE_BITS-1:0] remaining;
		bit neg;
		bit seen_digit;
		bit may_prefix;
		bit cr_held;
		bit over;
		logic [1:0] trail_cnt;
		logic [2:0] err;
		decoded_t pending_results[$];
		int mismatches;
		int results_seen;
		int beats;
		int payload_bytes;
		int dropped;
		int bodies_done;
		int err_hits[5];

		function new();
			restart();
		endfunction

		function void clear_line();
			phase = hcbd_pkg::PH_LWS;
			size_acc = '0;
			neg = 1'b0;
			seen_digit = 1'b0;
			may_prefix = 1'b0;
			cr_held = 1'b0;
			over = 1'b0;
		endfunction

		function void restart();
			clear_line();
			remaining = '0;
			trail_cnt = 2'd0;
			err = hcbd_pkg::ERR_NONE;
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c) - int'("0");
			if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
			if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
			return -1;
		endfunction

		function void take_digit(logic [7:0] c);
			int v;
			v = hex_digit(c);
			if (v < 0) begin
				phase = hcbd_pkg::PH_REST;
				return;
			end
			may_prefix = !seen_digit && v == 0;
			seen_digit = 1'b1;
			if (size_acc[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
				over = 1'b1;
			end else if (!over) begin
				size_acc = {size_acc[hcbd_pkg::SIZE_BITS-5:0], 4'(v)};
			end
			phase = hcbd_pkg::PH_DIGITS;
		endfunction

		function void size_char(logic [7:0] c);
			case (phase)
				hcbd_pkg::PH_LWS: begin
					if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return;
					if (c == "+") begin
						phase = hcbd_pkg::PH_SIGN;
					end else if (c == "-") begin
						neg = 1'b1;
						phase = hcbd_pkg::PH_SIGN;
					end else begin
						take_digit(c);
					end
				end
				hcbd_pkg::PH_SIGN: begin
					take_digit(c);
				end
				hcbd_pkg::PH_DIGITS: begin
					if (may_prefix && (c == "x" || c == "X")) begin
						may_prefix = 1'b0;
					end else begin
						take_digit(c);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void end_size_line();
			if (!seen_digit) begin
				err = hcbd_pkg::ERR_NO_DIGITS;
			end else if (neg && (size_acc != '0 || over)) begin
				err = hcbd_pkg::ERR_NEGATIVE;
			end else if (over) begin
				err = hcbd_pkg::ERR_OVERFLOW;
			end else if (size_acc == '0) begin
				phase = hcbd_pkg::PH_TRAIL;
				trail_cnt = 2'd2;
			end else begin
				remaining = size_acc;
				phase = hcbd_pkg::PH_DATA;
			end
			cr_held = 1'b0;
		endfunction

		function void take_byte(logic [7:0] c, logic st);
			decoded_t r;
			logic [2:0] err_was;
			bit done_was;
			r = '0;
			if (st) restart();
			err_was = err;
			done_was = (phase == hcbd_pkg::PH_DONE);
			beats++;
			if (err != hcbd_pkg::ERR_NONE || phase == hcbd_pkg::PH_DONE) begin
				r.ignored = 1'b1;
			end else if (phase <= hcbd_pkg::PH_REST) begin
				if (c == hcbd_pkg::CH_CR) begin
					if (cr_held) size_char(hcbd_pkg::CH_CR);
					cr_held = 1'b1;
				end else if (c == hcbd_pkg::CH_LF && cr_held) begin
					end_size_line();
				end else begin
					if (cr_held) begin
						size_char(hcbd_pkg::CH_CR);
						cr_held = 1'b0;
					end
					size_char(c);
				end
			end else if (phase == hcbd_pkg::PH_DATA) begin
				r.data = c;
				r.data_valid = 1'b1;
				remaining = remaining - 1'b1;
				if (remaining == '0) phase = hcbd_pkg::PH_DCR;
			end else if (phase == hcbd_pkg::PH_DCR) begin
				if (c == hcbd_pkg::CH_CR) phase = hcbd_pkg::PH_DLF;
				else err = hcbd_pkg::ERR_NO_CRLF;
			end else if (phase == hcbd_pkg::PH_DLF) begin
				if (c == hcbd_pkg::CH_LF) clear_line();
				else err = hcbd_pkg::ERR_NO_CRLF;
			end else begin
				// trailer section: the size line's crlf already counts as the first pair
				if (c == hcbd_pkg::CH_CR) begin
					trail_cnt = (trail_cnt == 2'd2) ? 2'd3 : 2'd1;
				end else if (c == hcbd_pkg::CH_LF) begin
					if (trail_cnt == 2'd3) begin
						phase = hcbd_pkg::PH_DONE;
						trail_cnt = 2'd0;
					end else begin
						trail_cnt = (trail_cnt == 2'd1) ? 2'd2 : 2'd0;
					end
				end else begin
					trail_cnt = 2'd0;
				end
			end
			r.done = (phase == hcbd_pkg::PH_DONE);
			r.err = err;
			if (r.ignored) dropped++;
			if (r.data_valid) payload_bytes++;
			if (r.done && !done_was) bodies_done++;
			if (err != err_was) err_hits[err]++;
			pending_results.insert(pending_results.size(), r);
		endfunction

		task report(string msg);
			$display("mismatch at result %0d: %s", results_seen, msg);
			mismatches++;
		endtask

		task compare(string field, logic [7:0] got, logic [7:0] want);
			if (got !== want) report($sformatf("%s got %0h, expected %0h", field, got, want));
		endtask

		task check_result(decoded_t got);
			decoded_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			want = pending_results.pop_front();
			compare("out_byte", got.data, want.data);
			compare("out_valid", got.data_valid, want.data_valid);
			compare("body_done", got.done, want.done);
			compare("error_code", got.err, want.err);
			compare("byte_ignored", got.ignored, want.ignored);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic start_body = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [7:0] out_byte;
	logic out_valid;
	logic body_done;
	logic [2:0] error_code;
	logic byte_ignored;

	chunk_scoreboard sb;
	logic [8:0] body_stream[$];
	bit pending_start = 1'b0;
	logic [7:0] last_byte = 8'h00;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int cycle_count = 0;

	http_chunked_body_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.start_body(start_body),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.body_done(body_done),
		.error_code(error_code),
		.byte_ignored(byte_ignored)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("http_chunked_body_decoder regression: fail");
			$finish;
		end
	end

	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic int hex_len(logic [31:0] v);
		int nd;
		nd = 1;
		while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
		return nd;
	endfunction

	function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
		logic [7:0] c;
		c = $urandom_range(0, 255);
		if (c == a || c == b) c = ":";
		return c;
	endfunction

	task automatic put_byte(logic [7:0] c);
		body_stream.insert(body_stream.size(), {pending_start, c});
		pending_start = 1'b0;
		last_byte = c;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(hcbd_pkg::CH_CR);
		put_byte(hcbd_pkg::CH_LF);
	endtask

	task automatic put_digit(logic [3:0] d);
		if (d < 4'd10) put_byte("0" + d);
		else put_byte(($urandom_range(0, 1) ? "A" : "a") + d - 4'd10);
	endtask

	task automatic put_hex(logic [31:0] v, int nd);
		for (int i = nd - 1; i >= 0; i--) put_digit(v[4*i +: 4]);
	endtask

	// leading white space, a bare cr or lf among it now and then
	task automatic put_ws();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: c = " ";
			1: c = 8'h09;
			2: c = 8'h0B;
			3: c = 8'h0C;
			4: c = hcbd_pkg::CH_CR;
			default: c = hcbd_pkg::CH_LF;
		endcase
		if (c == hcbd_pkg::CH_LF && last_byte == hcbd_pkg::CH_CR) c = " ";
		put_byte(c);
	endtask

	task automatic put_tail();
		put_byte($urandom_range(0, 1) ? ";" : " ");
		repeat ($urandom_range(0, 5)) put_byte(rand_byte_except(hcbd_pkg::CH_CR, hcbd_pkg::CH_CR));
	endtask

	task automatic put_size_line(logic [31:0] n);
		int z;
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_ws();
		case ($urandom_range(0, 7))
			0: put_byte("+");
			1: if (n == 0) put_byte("-");
			default: ;
		endcase
		z = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		if ($urandom_range(0, 3) == 0) begin
			put_byte("0");
			put_byte($urandom_range(0, 1) ? "x" : "X");
			// prefix with nothing after it
			if (n == 0 && $urandom_range(0, 1)) z = -1;
		end
		if (z >= 0) begin
			repeat (z) put_digit(4'h0);
			put_hex(n, hex_len(n));
		end
		if ($urandom_range(0, 2) == 0) put_tail();
		put_crlf();
	endtask

	task automatic put_chunk(int n);
		put_size_line(n);
		repeat (n) put_byte($urandom_range(0, 255));
		put_crlf();
	endtask

	task automatic put_good_chunks();
		repeat ($urandom_range(0, 3)) begin
			put_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
		end
	endtask

	task automatic put_random_body();
		int kind;
		int n;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		pending_start = 1'b1;
		if (kind < 70) begin
			put_good_chunks();
			put_size_line(0);
			repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0) begin
				repeat ($urandom_range(1, 6))
					put_byte(rand_byte_except(hcbd_pkg::CH_CR, hcbd_pkg::CH_LF));
				put_crlf();
			end
			put_crlf();
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte($urandom_range(0, 255));
		end else if (kind < 74) begin
			repeat ($urandom_range(0, 2)) put_ws();
			case ($urandom_range(0, 2))
				0: put_byte("+");
				1: put_byte("-");
				default: ;
			endcase
			if ($urandom_range(0, 1)) put_tail();
			put_crlf();
			put_byte($urandom_range(0, 255));
		end else if (kind < 79) begin
			put_good_chunks();
			put_byte("-");
			put_hex($urandom_range(1, 4095), hex_len(4095));
			put_crlf();
		end else if (kind < 84) begin
			put_good_chunks();
			if ($urandom_range(0, 2) == 0) put_byte("-");
			put_digit($urandom_range(1, 15));
			repeat ($urandom_range(8, 10)) put_digit($urandom_range(0, 15));
			put_crlf();
			put_byte($urandom_range(0, 255));
		end else if (kind < 90) begin
			put_good_chunks();
			n = $urandom_range(1, 4);
			put_size_line(n);
			repeat (n) put_byte($urandom_range(0, 255));
			if ($urandom_range(0, 1)) begin
				c = $urandom_range(0, 255);
				put_byte((c == hcbd_pkg::CH_CR) ? hcbd_pkg::CH_LF : c);
			end else begin
				put_byte(hcbd_pkg::CH_CR);
				c = $urandom_range(0, 255);
				put_byte((c == hcbd_pkg::CH_LF) ? hcbd_pkg::CH_CR : c);
			end
			put_byte($urandom_range(0, 255));
		end else if (kind < 95) begin
			// huge size, cut short by the next body
			put_size_line({4'($urandom_range(1, 15)), 28'($urandom)});
			repeat ($urandom_range(1, 6)) put_byte($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(3, 12)) put_byte($urandom_range(0, 255));
		end
	endtask

	task automatic build_directed();
		pending_start = 1'b1;
		put_text(" -0");
		put_crlf();
		put_crlf();
		put_byte(8'hFF);
		pending_start = 1'b1;
		put_text("0X;");
		put_crlf();
		put_text("a");
		put_crlf();
		put_crlf();
		pending_start = 1'b1;
		put_byte(hcbd_pkg::CH_CR);
		put_text("1");
		put_crlf();
		put_byte(8'h00);
		put_text("Q");
		pending_start = 1'b1;
		put_text("-1");
		put_crlf();
	endtask

	task automatic drive_inputs();
		int k;
		foreach (body_stream[i]) begin
			k = draw_wait(in_calm);
			if (k > 0) begin
				in_valid <= 1'b0;
				repeat (k) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= body_stream[i][7:0];
			start_body <= body_stream[i][8];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.take_byte(body_stream[i][7:0], body_stream[i][8]);
			if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
		end
		in_valid <= 1'b0;
	endtask

	task automatic take_results();
		int k;
		forever begin
			k = draw_wait(out_calm);
			if (k > 0) begin
				res_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			sb.check_result('{out_byte, out_valid, body_done, error_code, byte_ignored});
			if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
		end
	endtask

	initial begin
		int directed_len;
		sb = new();
		build_directed();
		directed_len = body_stream.size();
		while (body_stream.size() < directed_len + RANDOM_BEATS) put_random_body();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		fork
			take_results();
		join_none
		drive_inputs();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d beats checked, %0d payload bytes passed, %0d bodies finished, %0d dropped",
			sb.results_seen, sb.payload_bytes, sb.bodies_done, sb.dropped);
		$display("errors raised: %0d no size digits, %0d negative, %0d overflow, %0d missing crlf",
			sb.err_hits[hcbd_pkg::ERR_NO_DIGITS], sb.err_hits[hcbd_pkg::ERR_NEGATIVE],
			sb.err_hits[hcbd_pkg::ERR_OVERFLOW], sb.err_hits[hcbd_pkg::ERR_NO_CRLF]);
		if (sb.mismatches == 0) begin
			$display("http_chunked_body_decoder regression: pass");
		end else begin
			$display("http_chunked_body_decoder regression: fail");
		end
		$finish;
	end

endmodule

// ===== http_chunked_body_decoder.f =====
rtl/hcbd_pkg.sv
rtl/hcbd_front.sv
rtl/hcbd_queue.sv
rtl/hcbd_back.sv
rtl/http_chunked_body_decoder.sv
rtl/hcbd_checker.sv
tb/tb_http_chunked_body_decoder.sv
